>>> sv/vlfd_pkg.sv
// Shared types and constants for the varint length-prefixed frame deframer.
package vlfd_pkg;

  localparam int unsigned MAX_PREFIX_BYTES = 5;
  localparam int unsigned PREFIX_CNT_W     = $clog2(MAX_PREFIX_BYTES + 1);
  localparam int unsigned SHAMT_W          = $clog2(7 * (MAX_PREFIX_BYTES - 1) + 1);
  localparam int unsigned LEN_W            = 32;
  localparam int unsigned LEFT_W           = LEN_W - 1;

  typedef enum logic [1:0] {
    PH_PREFIX  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HALT    = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  localparam logic ERR_PREFIX_LONG = 1'b0;
  localparam logic ERR_NEG_LENGTH  = 1'b1;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
    logic       error_code;
  } result_t;

endpackage

>>> sv/varint_length_frame_deframer.sv
// Deframer that splits a byte stream into frames with base-128 length prefixes.
//
// The block takes one byte in every cycle unless in_stall_o is high: the frame
// state (prefix count, assembled length, payload bytes left) is updated as each
// byte is transferred in, and any result goes into an output register that is
// presented on the next cycle. A new byte is taken in the same cycle as the
// held result is transferred out, so in_stall_o is high only while a result
// waits and the output side stalls. After a framing error the block halts and
// drops every byte without result until reset.
module varint_length_frame_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] data_o,
  output logic       last_o,
  output logic       error_code_o
);

  vlfd_pkg::phase_e                        phase_q, phase_d;
  logic [vlfd_pkg::PREFIX_CNT_W-1:0]       prefix_cnt_q, prefix_cnt_d;
  logic [vlfd_pkg::LEN_W-1:0]              length_accum_q, length_accum_d;
  logic [vlfd_pkg::LEFT_W-1:0]             payload_left_q, payload_left_d;
  logic                                    out_valid_q;
  vlfd_pkg::result_t                       result_q, result_d;
  logic                                    emit;
  logic                                    in_xfer;
  logic                                    fin;
  logic [vlfd_pkg::SHAMT_W-1:0]            shamt;
  logic [vlfd_pkg::LEN_W-1:0]              merged_len;
  logic                                    too_long;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign fin        = (payload_left_q <= vlfd_pkg::LEFT_W'(1));
  assign too_long   = (prefix_cnt_q >= vlfd_pkg::PREFIX_CNT_W'(vlfd_pkg::MAX_PREFIX_BYTES));
  assign shamt      = vlfd_pkg::SHAMT_W'(prefix_cnt_q) * vlfd_pkg::SHAMT_W'(7);
  assign merged_len = length_accum_q
                    | (vlfd_pkg::LEN_W'(byte_in_i[6:0]) << shamt);

  // Next state of the frame tracker.
  always_comb begin
    phase_d        = phase_q;
    prefix_cnt_d   = prefix_cnt_q;
    length_accum_d = length_accum_q;
    payload_left_d = payload_left_q;
    if (in_xfer) begin
      case (phase_q)
        vlfd_pkg::PH_PAYLOAD: begin
          if (fin) begin
            payload_left_d = '0;
            phase_d        = vlfd_pkg::PH_PREFIX;
          end else begin
            payload_left_d = payload_left_q - vlfd_pkg::LEFT_W'(1);
          end
        end
        vlfd_pkg::PH_PREFIX: begin
          if (too_long) begin
            phase_d = vlfd_pkg::PH_HALT;
          end else if (byte_in_i[7]) begin
            length_accum_d = merged_len;
            prefix_cnt_d   = prefix_cnt_q + vlfd_pkg::PREFIX_CNT_W'(1);
          end else begin
            length_accum_d = '0;
            prefix_cnt_d   = '0;
            if (merged_len[vlfd_pkg::LEN_W-1]) begin
              phase_d = vlfd_pkg::PH_HALT;
            end else if (merged_len != '0) begin
              payload_left_d = merged_len[vlfd_pkg::LEFT_W-1:0];
              phase_d        = vlfd_pkg::PH_PAYLOAD;
            end
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // Result produced by the byte being transferred in, if any.
  always_comb begin
    emit                = 1'b0;
    result_d.kind       = vlfd_pkg::KIND_BYTE;
    result_d.data       = '0;
    result_d.last       = 1'b0;
    result_d.error_code = 1'b0;
    case (phase_q)
      vlfd_pkg::PH_PAYLOAD: begin
        emit          = 1'b1;
        result_d.data = byte_in_i;
        result_d.last = fin;
      end
      vlfd_pkg::PH_PREFIX: begin
        if (too_long) begin
          emit                = 1'b1;
          result_d.kind       = vlfd_pkg::KIND_ERROR;
          result_d.error_code = vlfd_pkg::ERR_PREFIX_LONG;
        end else if (!byte_in_i[7]) begin
          if (merged_len[vlfd_pkg::LEN_W-1]) begin
            emit                = 1'b1;
            result_d.kind       = vlfd_pkg::KIND_ERROR;
            result_d.error_code = vlfd_pkg::ERR_NEG_LENGTH;
          end else if (merged_len == '0) begin
            emit          = 1'b1;
            result_d.kind = vlfd_pkg::KIND_EMPTY;
            result_d.last = 1'b1;
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= vlfd_pkg::PH_PREFIX;
      prefix_cnt_q   <= '0;
      length_accum_q <= '0;
      payload_left_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      prefix_cnt_q   <= prefix_cnt_d;
      length_accum_q <= length_accum_d;
      payload_left_q <= payload_left_d;
      if (in_xfer) begin
        out_valid_q <= emit;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && emit) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = result_q.kind;
  assign data_o       = result_q.data;
  assign last_o       = result_q.last;
  assign error_code_o = result_q.error_code;

  halt_sticky_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == vlfd_pkg::PH_HALT |=> phase_q == vlfd_pkg::PH_HALT)
    else $error("Deframer left the halted phase without reset.");

  error_halts_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.kind == vlfd_pkg::KIND_ERROR |-> phase_q == vlfd_pkg::PH_HALT)
    else $error("An error result is held but the deframer is not halted.");

  prefix_cnt_range_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    prefix_cnt_q <= vlfd_pkg::PREFIX_CNT_W'(vlfd_pkg::MAX_PREFIX_BYTES))
    else $error("Prefix byte count exceeds its limit.");

  payload_nonzero_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == vlfd_pkg::PH_PAYLOAD |-> payload_left_q != '0)
    else $error("Payload phase entered with no payload bytes left.");

endmodule

>>> tb/tb_varint_length_frame_deframer.sv
// Self-checking testbench for the varint length-prefixed frame deframer.
module tb_varint_length_frame_deframer;

  typedef struct {
    logic [7:0]        value;
    bit                typed;
    bit                has_result;
    vlfd_pkg::result_t result;
    bit                drain_first;
  } link_row_t;

  localparam vlfd_pkg::result_t NO_RESULT   = '{vlfd_pkg::KIND_BYTE, 8'h00, 1'b0, 1'b0};
  localparam vlfd_pkg::result_t EMPTY_FRAME = '{vlfd_pkg::KIND_EMPTY, 8'h00, 1'b1, 1'b0};
  localparam int unsigned RANDOM_BYTES = 1300;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] byte_in = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [1:0] kind_o;
  logic [7:0] data_o;
  logic       last_o;
  logic       error_code_o;

  link_row_t         directed_rows [19];
  link_row_t         link_bytes [$];
  vlfd_pkg::result_t pending_results [$];
  int unsigned       row_idx = 0;
  int unsigned       failures = 0;
  int unsigned       cycle_count = 0;
  wire               calm = (cycle_count % 1000) < 150;

  vlfd_pkg::phase_e                  fr_phase = vlfd_pkg::PH_PREFIX;
  logic [vlfd_pkg::PREFIX_CNT_W-1:0] fr_prefix_cnt = '0;
  logic [vlfd_pkg::LEN_W-1:0]        fr_length = '0;
  logic [vlfd_pkg::LEFT_W-1:0]       fr_left = '0;

  varint_length_frame_deframer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .byte_in_i    (byte_in),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .kind_o       (kind_o),
    .data_o       (data_o),
    .last_o       (last_o),
    .error_code_o (error_code_o)
  );

  function automatic bit deframe_byte(input logic [7:0] b, output vlfd_pkg::result_t res);
    logic [vlfd_pkg::LEN_W-1:0] len;
    res = NO_RESULT;
    case (fr_phase)
      vlfd_pkg::PH_PAYLOAD: begin
        res.data = b;
        if (fr_left <= 1) begin
          res.last = 1'b1;
          fr_left = '0;
          fr_phase = vlfd_pkg::PH_PREFIX;
        end else begin
          fr_left = fr_left - 1'b1;
        end
        return 1'b1;
      end
      vlfd_pkg::PH_PREFIX: begin
        if (fr_prefix_cnt >= vlfd_pkg::MAX_PREFIX_BYTES) begin
          fr_phase = vlfd_pkg::PH_HALT;
          res.kind = vlfd_pkg::KIND_ERROR;
          res.error_code = vlfd_pkg::ERR_PREFIX_LONG;
          return 1'b1;
        end
        fr_length = fr_length | (vlfd_pkg::LEN_W'(b[6:0]) << (7 * fr_prefix_cnt));
        fr_prefix_cnt = fr_prefix_cnt + 1'b1;
        if (b[7]) return 1'b0;
        len = fr_length;
        fr_prefix_cnt = '0;
        fr_length = '0;
        if (len[vlfd_pkg::LEN_W-1]) begin
          fr_phase = vlfd_pkg::PH_HALT;
          res.kind = vlfd_pkg::KIND_ERROR;
          res.error_code = vlfd_pkg::ERR_NEG_LENGTH;
          return 1'b1;
        end
        if (len == 0) begin
          res = EMPTY_FRAME;
          return 1'b1;
        end
        fr_left = len[vlfd_pkg::LEFT_W-1:0];
        fr_phase = vlfd_pkg::PH_PAYLOAD;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic push_byte(input logic [7:0] value, input bit drain,
                           input bit typed = 1'b0, input bit has = 1'b0,
                           input vlfd_pkg::result_t res = NO_RESULT);
    link_row_t row;
    row.value = value;
    row.typed = typed;
    row.has_result = has;
    row.result = res;
    row.drain_first = drain;
    link_bytes.push_back(row);
  endtask

  task automatic add_frame(input bit drain);
    int unsigned len;
    int unsigned groups;
    int unsigned r;
    logic [6:0]  grp;
    r = $urandom_range(0, 99);
    if (r < 10) len = 0;
    else if (r < 80) len = $urandom_range(1, 8);
    else if (r < 95) len = $urandom_range(9, 40);
    else len = $urandom_range(41, 300);
    groups = 1;
    while ((len >> (7 * groups)) != 0) groups++;
    if ($urandom_range(0, 3) == 0)
      groups = groups + $urandom_range(0, vlfd_pkg::MAX_PREFIX_BYTES - groups);
    for (int unsigned i = 0; i < groups; i++) begin
      grp = 7'((len >> (7 * i)) & 32'h7F);
      if (i == vlfd_pkg::MAX_PREFIX_BYTES - 1) grp = grp | 7'($urandom_range(0, 7) << 4);
      push_byte({i < groups - 1, grp}, drain && i == 0);
    end
    for (int unsigned i = 0; i < len; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      failures++;
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  always @(posedge clk_i or negedge rst_ni) begin : rx_side
    int unsigned stall_left;
    if (!rst_ni) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : tx_and_check
    vlfd_pkg::result_t want;
    vlfd_pkg::result_t got;
    bit                hit;
    bit                next_valid;
    int unsigned       gap_left;
    if (!rst_ni) begin
      gap_left = 0;
      in_valid <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        got = '{vlfd_pkg::kind_e'(kind_o), data_o, last_o, error_code_o};
        if (pending_results.size() == 0) begin
          $display("%0t: no result expected, got kind %0d data %0h", $time, kind_o, data_o);
          failures++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", want.kind, got.kind);
          check_field("data", want.data, got.data);
          check_field("last", want.last, got.last);
          check_field("error_code", want.error_code, got.error_code);
        end
      end
      if (in_valid && !in_stall_o) begin
        hit = deframe_byte(link_bytes[row_idx].value, want);
        if (link_bytes[row_idx].typed) begin
          hit = link_bytes[row_idx].has_result;
          want = link_bytes[row_idx].result;
        end
        if (hit) pending_results.push_back(want);
        row_idx++;
        gap_left = pick_gap();
      end
      next_valid = in_valid;
      if (!(in_valid && in_stall_o)) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (row_idx < link_bytes.size() &&
                     !(link_bytes[row_idx].drain_first && pending_results.size() != 0)) begin
          next_valid = 1'b1;
          byte_in <= link_bytes[row_idx].value;
        end
      end
      in_valid <= next_valid;
    end
  end

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    directed_rows = '{
      '{8'h00, 1'b1, 1'b1, EMPTY_FRAME, 1'b0},
      '{8'h01, 1'b1, 1'b0, NO_RESULT, 1'b0},
      '{8'hFF, 1'b1, 1'b1, '{vlfd_pkg::KIND_BYTE, 8'hFF, 1'b1, 1'b0}, 1'b0},
      '{8'h02, 1'b1, 1'b0, NO_RESULT, 1'b0},
      '{8'h00, 1'b1, 1'b1, '{vlfd_pkg::KIND_BYTE, 8'h00, 1'b0, 1'b0}, 1'b0},
      '{8'h80, 1'b1, 1'b1, '{vlfd_pkg::KIND_BYTE, 8'h80, 1'b1, 1'b0}, 1'b0},
      '{8'h80, 1'b1, 1'b0, NO_RESULT, 1'b0},
      '{8'h00, 1'b1, 1'b1, EMPTY_FRAME, 1'b0},
      '{8'h81, 1'b1, 1'b0, NO_RESULT, 1'b0},
      '{8'h80, 1'b1, 1'b0, NO_RESULT, 1'b0},
      '{8'h80, 1'b1, 1'b0, NO_RESULT, 1'b0},
      '{8'h80, 1'b1, 1'b0, NO_RESULT, 1'b0},
      '{8'h70, 1'b1, 1'b0, NO_RESULT, 1'b0},
      '{8'h5A, 1'b1, 1'b1, '{vlfd_pkg::KIND_BYTE, 8'h5A, 1'b1, 1'b0}, 1'b0},
      '{8'h83, 1'b0, 1'b0, NO_RESULT, 1'b0},
      '{8'h00, 1'b0, 1'b0, NO_RESULT, 1'b0},
      '{8'h7F, 1'b0, 1'b0, NO_RESULT, 1'b0},
      '{8'h01, 1'b0, 1'b0, NO_RESULT, 1'b0},
      '{8'hAA, 1'b0, 1'b0, NO_RESULT, 1'b0}
    };
    foreach (directed_rows[i]) link_bytes.push_back(directed_rows[i]);
    add_frame(1'b1);
    while (link_bytes.size() < $size(directed_rows) + RANDOM_BYTES)
      add_frame($urandom_range(0, 39) == 0);
    // The block halts on a framing error, so one error case closes the run.
    for (int unsigned i = 0; i < vlfd_pkg::MAX_PREFIX_BYTES - 1; i++)
      push_byte(8'h80, i == 0, 1'b1);
    if ($urandom_range(0, 1) == 0) begin
      push_byte(8'h80, 1'b0, 1'b1);
      push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1,
                '{vlfd_pkg::KIND_ERROR, 8'h00, 1'b0, vlfd_pkg::ERR_PREFIX_LONG});
    end else begin
      push_byte(8'h08, 1'b0, 1'b1, 1'b1,
                '{vlfd_pkg::KIND_ERROR, 8'h00, 1'b0, vlfd_pkg::ERR_NEG_LENGTH});
    end
    for (int unsigned i = 0; i < 4; i++) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (row_idx < link_bytes.size() || pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> varint_length_frame_deframer.f
sv/vlfd_pkg.sv
sv/varint_length_frame_deframer.sv
tb/tb_varint_length_frame_deframer.sv
